// ===== sv/ptd_pkg.sv =====
`timescale 1ns / 1ps

package ptd_pkg;

    // Table sizes
    localparam int MAX_TASKS  = 16;
    localparam int MAX_EVENTS = 16;

    localparam int TIDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TCNT_W = $clog2(MAX_TASKS + 1);
    localparam int EIDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int ECNT_W = $clog2(MAX_EVENTS + 1);

    // Field widths
    localparam int PERIOD_W = 32;
    localparam int EVENT_W  = 8;
    localparam int ID_W     = 8;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 3;

    // Packed stream words
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_DISPATCH   = 2'd1,
        OP_ADD_TASK   = 2'd2,
        OP_POST_EVENT = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE       = 3'd0,
        KIND_EVENT      = 3'd1,
        KIND_TASK       = 3'd2,
        KIND_TABLE_FULL = 3'd3,
        KIND_STACK_FULL = 3'd4,
        KIND_BUSY       = 3'd5
    } t_kind;

    // Event stack status toward the sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } t_evs_status;

endpackage

// ===== sv/ptd_event_stack.sv =====
`timescale 1ns / 1ps

module ptd_event_stack (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [ptd_pkg::EVENT_W-1:0] i_push_id,
    input  logic                      i_pop,
    output logic [ptd_pkg::EVENT_W-1:0] o_pop_id,
    output ptd_pkg::t_evs_status      o_status
);

    logic [ptd_pkg::EVENT_W-1:0] r_stack_mem [ptd_pkg::MAX_EVENTS];
    logic [ptd_pkg::ECNT_W-1:0]  r_count;
    logic [ptd_pkg::EVENT_W-1:0] r_pop_id;
    logic [ptd_pkg::ECNT_W-1:0]  top_pos;
    logic                        is_full;
    logic                        is_empty;

    assign is_full  = (r_count == ptd_pkg::ECNT_W'(ptd_pkg::MAX_EVENTS));
    assign is_empty = (r_count == '0);
    assign top_pos  = r_count - ptd_pkg::ECNT_W'(1);

    // Stack memory: push writes the next free slot, pop reads the top
    always_ff @(posedge i_clk) begin
        if (i_push && !is_full) begin
            r_stack_mem[r_count[ptd_pkg::EIDX_W-1:0]] <= i_push_id;
        end
        if (i_pop && !is_empty) begin
            r_pop_id <= r_stack_mem[top_pos[ptd_pkg::EIDX_W-1:0]];
        end
    end

    // Fill count; a push to a full stack is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_push && !is_full) begin
            r_count <= r_count + ptd_pkg::ECNT_W'(1);
        end else if (i_pop && !is_empty) begin
            r_count <= top_pos;
        end
    end

    assign o_pop_id       = r_pop_id;
    assign o_status.empty = is_empty;
    assign o_status.full  = is_full;

endmodule

// ===== sv/periodic_task_dispatcher_top.sv =====
`timescale 1ns / 1ps

// Periodic task dispatcher.
// Input stream: tuser carries the operation (tick, dispatch, add task, post
// event); tdata carries task_period in [31:0] and event_id in [39:32].
// Output stream: tuser carries the result kind, tdata the dispatched event id
// or task index, tlast marks the final word of one input word.
// One input word is worked on at a time; the input is ready again once the
// sequencer is back in idle and the output register is free or draining.
// Add task, post event and a dispatch without a pending event give their
// word in the cycle after acceptance. A dispatch with a pending event reads
// the top of the event stack and gives the event word, then the task word if
// a task is pending. A tick sweeps the task memories one entry per cycle,
// incrementing each elapsed count and checking it against its period, then
// goes through the drain and finish states up to its result word; with an
// empty table it goes straight to the finish state.
// A stalled output holds its word and the sequencer waits; no word is lost.
// Reset (synchronous, active low) empties the task table and event stack and
// clears all pending marks; no memory clearing pass is needed.

module periodic_task_dispatcher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [31:0] task_period, [39:32] event_id
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] dispatch_id
    output logic [2:0]  o_m_axis_tuser,   // [2:0] result_kind
    output logic        o_m_axis_tlast    // last
);

    localparam int TIDX_W   = ptd_pkg::TIDX_W;
    localparam int TCNT_W   = ptd_pkg::TCNT_W;
    localparam int PERIOD_W = ptd_pkg::PERIOD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_FINISH,
        S_EVENT,
        S_TASK
    } t_state;

    t_state                     r_state;
    logic [TCNT_W-1:0]          r_task_count;
    logic [TIDX_W-1:0]          r_search_ptr;
    logic                       r_task_pending;
    logic                       r_event_pending;
    logic [TIDX_W-1:0]          r_pend_idx;
    logic [TCNT_W-1:0]          r_rd_idx;
    logic                       r_chk_valid;
    logic [TIDX_W-1:0]          r_chk_idx;
    logic                       r_busy_tick;
    logic                       r_found_hi;
    logic [TIDX_W-1:0]          r_hi_idx;
    logic                       r_found_lo;
    logic [TIDX_W-1:0]          r_lo_idx;
    logic                       r_out_valid;
    ptd_pkg::t_kind             r_out_kind;
    logic [ptd_pkg::ID_W-1:0]   r_out_id;
    logic                       r_out_last;

    logic [PERIOD_W-1:0]        r_period_mem  [ptd_pkg::MAX_TASKS];
    logic [PERIOD_W-1:0]        r_elapsed_mem [ptd_pkg::MAX_TASKS];
    logic [PERIOD_W-1:0]        r_period_q;
    logic [PERIOD_W-1:0]        r_elapsed_q;

    logic                       in_fire;
    logic                       out_free;
    ptd_pkg::t_op               in_op;
    logic [PERIOD_W-1:0]        in_period;
    logic [ptd_pkg::EVENT_W-1:0] in_event;
    logic                       table_full;
    logic [PERIOD_W-1:0]        elapsed_inc;
    logic                       chk_fire;
    logic                       found;
    logic [TIDX_W-1:0]          win_idx;
    logic                       el_we;
    logic [TIDX_W-1:0]          el_waddr;
    logic [PERIOD_W-1:0]        el_wdata;
    logic                       evs_push;
    logic                       evs_pop;
    logic [ptd_pkg::EVENT_W-1:0] evs_pop_id;
    ptd_pkg::t_evs_status       evs_status;

    // Handshake and field unpacking
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign in_op           = ptd_pkg::t_op'(i_s_axis_tuser);
    assign in_period       = i_s_axis_tdata[31:0];
    assign in_event        = i_s_axis_tdata[39:32];
    assign table_full      = (r_task_count == TCNT_W'(ptd_pkg::MAX_TASKS));

    // Check stage of the tick sweep
    assign elapsed_inc = r_elapsed_q + PERIOD_W'(1);
    assign chk_fire    = elapsed_inc > r_period_q;
    assign found       = r_found_hi || r_found_lo;
    assign win_idx     = r_found_hi ? r_hi_idx : r_lo_idx;

    // Elapsed memory write port: seed on add, increment in sweep, clear winner
    always_comb begin
        el_we    = 1'b0;
        el_waddr = r_chk_idx;
        el_wdata = elapsed_inc;
        if (r_state == S_IDLE && in_fire && in_op == ptd_pkg::OP_ADD_TASK && !table_full) begin
            el_we    = 1'b1;
            el_waddr = r_task_count[TIDX_W-1:0];
            el_wdata = PERIOD_W'(r_task_count);
        end else if (r_chk_valid) begin
            el_we    = 1'b1;
            el_waddr = r_chk_idx;
            el_wdata = elapsed_inc;
        end else if (r_state == S_FINISH && out_free && !r_busy_tick && found) begin
            el_we    = 1'b1;
            el_waddr = win_idx;
            el_wdata = '0;
        end
    end

    // Task memories, registered read at the sweep address
    always_ff @(posedge i_clk) begin
        if (el_we) begin
            r_elapsed_mem[el_waddr] <= el_wdata;
        end
        if (r_state == S_IDLE && in_fire && in_op == ptd_pkg::OP_ADD_TASK && !table_full) begin
            r_period_mem[r_task_count[TIDX_W-1:0]] <= in_period;
        end
        r_elapsed_q <= r_elapsed_mem[r_rd_idx[TIDX_W-1:0]];
        r_period_q  <= r_period_mem[r_rd_idx[TIDX_W-1:0]];
    end

    // Event stack
    assign evs_push = in_fire && in_op == ptd_pkg::OP_POST_EVENT;
    assign evs_pop  = in_fire && in_op == ptd_pkg::OP_DISPATCH && r_event_pending
                      && !evs_status.empty;

    ptd_event_stack u_event_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (evs_push),
        .i_push_id (in_event),
        .i_pop     (evs_pop),
        .o_pop_id  (evs_pop_id),
        .o_status  (evs_status)
    );

    // Sequencer with registered output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_task_count    <= '0;
            r_search_ptr    <= '0;
            r_task_pending  <= 1'b0;
            r_event_pending <= 1'b0;
            r_pend_idx      <= '0;
            r_rd_idx        <= '0;
            r_chk_valid     <= 1'b0;
            r_chk_idx       <= '0;
            r_busy_tick     <= 1'b0;
            r_found_hi      <= 1'b0;
            r_hi_idx        <= '0;
            r_found_lo      <= 1'b0;
            r_lo_idx        <= '0;
            r_out_valid     <= 1'b0;
            r_out_kind      <= ptd_pkg::KIND_DONE;
            r_out_id        <= '0;
            r_out_last      <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_chk_valid <= 1'b0;

            // first firing task at or after the search pointer, else before it
            if (r_chk_valid && chk_fire) begin
                if (r_chk_idx >= r_search_ptr) begin
                    if (!r_found_hi) begin
                        r_found_hi <= 1'b1;
                        r_hi_idx   <= r_chk_idx;
                    end
                end else if (!r_found_lo) begin
                    r_found_lo <= 1'b1;
                    r_lo_idx   <= r_chk_idx;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (in_op)
                            ptd_pkg::OP_TICK: begin
                                r_busy_tick <= r_task_pending || r_event_pending;
                                r_found_hi  <= 1'b0;
                                r_found_lo  <= 1'b0;
                                r_rd_idx    <= '0;
                                r_state     <= (r_task_count != '0) ? S_SWEEP : S_FINISH;
                            end
                            ptd_pkg::OP_DISPATCH: begin
                                r_event_pending <= 1'b0;
                                if (r_event_pending && !evs_status.empty) begin
                                    r_state <= S_EVENT;
                                end else if (r_task_pending) begin
                                    r_task_pending <= 1'b0;
                                    r_out_valid    <= 1'b1;
                                    r_out_kind     <= ptd_pkg::KIND_TASK;
                                    r_out_id       <= ptd_pkg::ID_W'(r_pend_idx);
                                    r_out_last     <= 1'b1;
                                end else begin
                                    r_out_valid <= 1'b1;
                                    r_out_kind  <= ptd_pkg::KIND_DONE;
                                    r_out_id    <= '0;
                                    r_out_last  <= 1'b1;
                                end
                            end
                            ptd_pkg::OP_ADD_TASK: begin
                                if (!table_full) begin
                                    r_task_count <= r_task_count + TCNT_W'(1);
                                end
                                r_out_valid <= 1'b1;
                                r_out_kind  <= table_full ? ptd_pkg::KIND_TABLE_FULL
                                                          : ptd_pkg::KIND_DONE;
                                r_out_id    <= '0;
                                r_out_last  <= 1'b1;
                            end
                            ptd_pkg::OP_POST_EVENT: begin
                                r_out_valid <= 1'b1;
                                r_out_kind  <= evs_status.full ? ptd_pkg::KIND_STACK_FULL
                                                               : ptd_pkg::KIND_DONE;
                                r_out_id    <= '0;
                                r_out_last  <= 1'b1;
                            end
                        endcase
                    end
                end

                // one task entry read per cycle
                S_SWEEP: begin
                    r_chk_valid <= 1'b1;
                    r_chk_idx   <= r_rd_idx[TIDX_W-1:0];
                    r_rd_idx    <= r_rd_idx + TCNT_W'(1);
                    if (r_rd_idx == r_task_count - TCNT_W'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end

                S_DRAIN: begin
                    r_state <= S_FINISH;
                end

                S_FINISH: begin
                    if (out_free) begin
                        if (!r_busy_tick) begin
                            if (found) begin
                                r_task_pending <= 1'b1;
                                r_pend_idx     <= win_idx;
                                r_search_ptr   <= win_idx;
                            end
                            if (!evs_status.empty) begin
                                r_event_pending <= 1'b1;
                            end
                        end
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_busy_tick ? ptd_pkg::KIND_BUSY : ptd_pkg::KIND_DONE;
                        r_out_id    <= '0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                // popped event id is ready in the cycle after the pop
                S_EVENT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= ptd_pkg::KIND_EVENT;
                        r_out_id    <= ptd_pkg::ID_W'(evs_pop_id);
                        r_out_last  <= !r_task_pending;
                        r_state     <= r_task_pending ? S_TASK : S_IDLE;
                    end
                end

                S_TASK: begin
                    if (out_free) begin
                        r_task_pending <= 1'b0;
                        r_out_valid    <= 1'b1;
                        r_out_kind     <= ptd_pkg::KIND_TASK;
                        r_out_id       <= ptd_pkg::ID_W'(r_pend_idx);
                        r_out_last     <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_id;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

endmodule
